// ===== rtl/elts_pkg.sv =====
// shared types and constants for the emergency light tick scheduler
`default_nettype none

package elts_pkg;

    // field widths
    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned CFG_W    = 10;

    // calendar moduli
    localparam int unsigned TICKS_PER_SECOND       = 10;
    localparam int unsigned SECONDS_PER_MINUTE     = 60;
    localparam int unsigned MINUTES_PER_HOUR       = 60;
    localparam int unsigned HOURS_PER_DAY          = 24;
    localparam int unsigned DAYS_PER_WEEK          = 7;
    localparam int unsigned WEEKS_PER_YEAR         = 52;
    localparam int unsigned SECONDS_PER_EVENT      = 5;
    localparam int unsigned SECONDS_PER_SLOW_CYCLE = 5;

    // reset values
    localparam logic [CFG_W-1:0] FAIL_THR_RESET    = 10'd1023;
    localparam logic [CFG_W-1:0] RESTORE_THR_RESET = 10'd0;
    localparam logic [2:0]       EVENT_CNT_RESET   = 3'd3;

    // configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FAIL_THRESHOLD    = 1'b0;
    localparam t_cfg_idx CFG_RESTORE_THRESHOLD = 1'b1;

    typedef struct packed {
        logic             we;
        t_cfg_idx         index;
        logic [CFG_W-1:0] data;
    } t_cfg_wr;

    // per-tick calendar status, next value after the tick
    typedef struct packed {
        logic                event_pulse;
        logic                weekly_request;
        logic                yearly_request;
        logic                charger_drive;
        logic [MINUTE_W-1:0] elapsed_minutes;
        logic [HOUR_W-1:0]   elapsed_hours;
    } t_cal_status;

endpackage

`default_nettype wire

// ===== rtl/elts_in_if.sv =====
// request channel carrying one tick with its mains sample
`default_nettype none

interface elts_in_if;
    logic                          valid;
    logic                          ready;
    logic [elts_pkg::SAMPLE_W-1:0] power_sample;
    logic                          fast_charge_on;
    logic                          clear_calendar;

    modport source (
        output valid, power_sample, fast_charge_on, clear_calendar,
        input  ready
    );

    modport sink (
        input  valid, power_sample, fast_charge_on, clear_calendar,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/elts_out_if.sv =====
// result channel carrying the scheduler status after one tick
`default_nettype none

interface elts_out_if;
    logic                          valid;
    logic                          ready;
    logic                          power_fail;
    logic                          event_pulse;
    logic                          weekly_request;
    logic                          yearly_request;
    logic                          charger_drive;
    logic [elts_pkg::MINUTE_W-1:0] elapsed_minutes;
    logic [elts_pkg::HOUR_W-1:0]   elapsed_hours;

    modport source (
        output valid, power_fail, event_pulse, weekly_request, yearly_request,
               charger_drive, elapsed_minutes, elapsed_hours,
        input  ready
    );

    modport sink (
        input  valid, power_fail, event_pulse, weekly_request, yearly_request,
               charger_drive, elapsed_minutes, elapsed_hours,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/elts_mains.sv =====
// threshold registers and hysteresis power-fail flag
`default_nettype none

module elts_mains (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire elts_pkg::t_cfg_wr             i_cfg,
    input  wire logic                          i_advance,
    input  wire logic [elts_pkg::SAMPLE_W-1:0] i_sample,
    output logic                               o_fail_next
);
    import elts_pkg::*;

    logic [CFG_W-1:0] r_fail_thr;
    logic [CFG_W-1:0] r_restore_thr;
    logic             r_fail_flag;
    logic             n_fail_flag;

    // set above fail threshold, clear below restore threshold
    always_comb begin
        n_fail_flag = r_fail_flag;
        if (!r_fail_flag) begin
            if (i_sample > r_fail_thr) n_fail_flag = 1'b1;
        end else begin
            if (i_sample < r_restore_thr) n_fail_flag = 1'b0;
        end
    end

    assign o_fail_next = n_fail_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_thr    <= FAIL_THR_RESET;
            r_restore_thr <= RESTORE_THR_RESET;
            r_fail_flag   <= 1'b0;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.index)
                    CFG_FAIL_THRESHOLD:    r_fail_thr    <= i_cfg.data;
                    CFG_RESTORE_THRESHOLD: r_restore_thr <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_advance) r_fail_flag <= n_fail_flag;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/elts_calendar.sv =====
// tick, calendar, event and slow charge counters
`default_nettype none

module elts_calendar (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_advance,
    input  wire logic          i_clear,
    input  wire logic          i_fast,
    output elts_pkg::t_cal_status o_status
);
    import elts_pkg::*;

    logic [3:0]          r_tick;
    logic [5:0]          r_sec;
    logic [MINUTE_W-1:0] r_min;
    logic [HOUR_W-1:0]   r_hour;
    logic [2:0]          r_day;
    logic [5:0]          r_week;
    logic [2:0]          r_event;
    logic [2:0]          r_slow;
    logic                r_drive;

    logic [3:0]          n_tick;
    logic [5:0]          n_sec;
    logic [MINUTE_W-1:0] n_min;
    logic [HOUR_W-1:0]   n_hour;
    logic [2:0]          n_day;
    logic [5:0]          n_week;
    logic [2:0]          n_event;
    logic [2:0]          n_slow;
    logic                n_drive;

    logic [5:0]          b_sec;
    logic [MINUTE_W-1:0] b_min;
    logic [HOUR_W-1:0]   b_hour;
    logic [2:0]          b_day;
    logic [5:0]          b_week;
    logic                w_tick, w_sec, w_min, w_hour, w_day, w_week, w_event, w_slow;

    always_comb begin
        // calendar clear applies before this tick counts
        b_sec  = i_clear ? '0 : r_sec;
        b_min  = i_clear ? '0 : r_min;
        b_hour = i_clear ? '0 : r_hour;
        b_day  = i_clear ? '0 : r_day;
        b_week = i_clear ? '0 : r_week;

        w_tick  = r_tick >= 4'(TICKS_PER_SECOND - 1);
        w_sec   = w_tick && (b_sec  >= 6'(SECONDS_PER_MINUTE - 1));
        w_min   = w_sec  && (b_min  >= MINUTE_W'(MINUTES_PER_HOUR - 1));
        w_hour  = w_min  && (b_hour >= HOUR_W'(HOURS_PER_DAY - 1));
        w_day   = w_hour && (b_day  >= 3'(DAYS_PER_WEEK - 1));
        w_week  = w_day  && (b_week >= 6'(WEEKS_PER_YEAR - 1));
        w_event = w_tick && (r_event >= 3'(SECONDS_PER_EVENT - 1));
        w_slow  = r_slow >= 3'(SECONDS_PER_SLOW_CYCLE - 1);

        n_tick = w_tick ? '0 : r_tick + 4'd1;
        n_sec  = w_tick ? (w_sec  ? '0 : b_sec  + 6'd1) : b_sec;
        n_min  = w_sec  ? (w_min  ? '0 : b_min  + MINUTE_W'(1)) : b_min;
        n_hour = w_min  ? (w_hour ? '0 : b_hour + HOUR_W'(1)) : b_hour;
        n_day  = w_hour ? (w_day  ? '0 : b_day  + 3'd1) : b_day;
        n_week = w_day  ? (w_week ? '0 : b_week + 6'd1) : b_week;
        n_event = w_tick ? (w_event ? '0 : r_event + 3'd1) : r_event;

        // slow charge holds while fast charge is on
        n_slow  = r_slow;
        n_drive = r_drive;
        if (w_tick && !i_fast) begin
            n_slow  = w_slow ? '0 : r_slow + 3'd1;
            n_drive = w_slow;
        end

        o_status.event_pulse     = w_event;
        o_status.weekly_request  = w_day;
        o_status.yearly_request  = w_week;
        o_status.charger_drive   = n_drive;
        o_status.elapsed_minutes = n_min;
        o_status.elapsed_hours   = n_hour;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_sec   <= '0;
            r_min   <= '0;
            r_hour  <= '0;
            r_day   <= '0;
            r_week  <= '0;
            r_event <= EVENT_CNT_RESET;
            r_slow  <= '0;
            r_drive <= 1'b0;
        end else if (i_advance) begin
            r_tick  <= n_tick;
            r_sec   <= n_sec;
            r_min   <= n_min;
            r_hour  <= n_hour;
            r_day   <= n_day;
            r_week  <= n_week;
            r_event <= n_event;
            r_slow  <= n_slow;
            r_drive <= n_drive;
        end
    end

    // a week wrap lands on midnight
    a_weekly_midnight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_day |-> (n_hour == '0) && (n_min == '0) && (n_sec == '0))
        else $error("weekly request off midnight");

    // the clock held still while no tick advanced
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(i_advance) |-> $stable(r_tick) && $stable(r_event))
        else $error("counters moved without a tick");

endmodule

`default_nettype wire

// ===== rtl/emergency_light_tick_scheduler.sv =====
// emergency light tick scheduler top level: input stage, mains flag, calendar, result stage
// path: an accepted request is held in the input stage, and the result register loads when
//   the input stage advances, which waits while a stalled result is held
// throughput: one request per cycle while o_rsp is ready, one pass input to result register
// reset (synchronous, active low): both stages empty, counters zero except event count 3,
//   fail threshold 1023, restore threshold 0
`default_nettype none

module emergency_light_tick_scheduler (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_index,
    input  wire logic [elts_pkg::CFG_W-1:0]   i_cfg_wdata,
    elts_in_if.sink                           i_req,
    elts_out_if.source                        o_rsp
);
    import elts_pkg::*;

    // input stage
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_fast;
    logic                r_clear;

    // result stage
    logic                r_out_valid;
    logic                r_power_fail;
    t_cal_status         r_status;

    logic                advance;
    logic                fail_next;
    t_cal_status         cal_next;
    t_cfg_wr             cfg;

    // the input stage moves on when the result register is empty or being drained
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = t_cfg_idx'(i_cfg_index);
    assign cfg.data  = i_cfg_wdata;

    elts_mains u_mains (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_advance   (advance),
        .i_sample    (r_sample),
        .o_fail_next (fail_next)
    );

    elts_calendar u_calendar (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_clear   (r_clear),
        .i_fast    (r_fast),
        .o_status  (cal_next)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) r_in_valid <= i_req.valid;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_sample <= i_req.power_sample;
            r_fast   <= i_req.fast_charge_on;
            r_clear  <= i_req.clear_calendar;
        end
        if (advance) begin
            r_power_fail <= fail_next;
            r_status     <= cal_next;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.power_fail      = r_power_fail;
    assign o_rsp.event_pulse     = r_status.event_pulse;
    assign o_rsp.weekly_request  = r_status.weekly_request;
    assign o_rsp.yearly_request  = r_status.yearly_request;
    assign o_rsp.charger_drive   = r_status.charger_drive;
    assign o_rsp.elapsed_minutes = r_status.elapsed_minutes;
    assign o_rsp.elapsed_hours   = r_status.elapsed_hours;

    // a year wrap is always also a week wrap
    a_yearly_weekly: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status.yearly_request |-> r_status.weekly_request)
        else $error("yearly request without weekly request");

    // backpressure only when the input stage holds a request
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> r_in_valid && r_out_valid && !o_rsp.ready)
        else $error("input stalled with room to advance");

    // reset leaves both stages empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("stage valid after reset");

    // a stalled result is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_rsp.ready |-> !advance)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
